// ----- sv/i2cdbt_pkg.sv -----
// Package for the I2C debug byte transmitter.
// Holds the sequencer phase type, the block's interface structs and register indexes.
// No dependencies.
package i2cdbt_pkg;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_ST_SDA_SYNC,
    PH_ST_SCL_SYNC,
    PH_ST_SETUP,
    PH_ST_HOLD,
    PH_ST_LOW,
    PH_BIT_SETUP,
    PH_BIT_SYNC,
    PH_BIT_HIGH,
    PH_BIT_LOW,
    PH_ACK_SETUP,
    PH_ACK_SYNC,
    PH_ACK_SAMPLE,
    PH_ACK_HOLD,
    PH_ACK_TAIL,
    PH_CLN_SCL,
    PH_CLN_SDA,
    PH_RETRY,
    PH_SP_LOW,
    PH_SP_SYNC,
    PH_SP_HIGH,
    PH_SP_SDA_SYNC,
    PH_SP_TAIL
  } phase_e;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_BIT_DELAY = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TARGET_ADDRESS = 2'd1;

  localparam logic [15:0] BIT_DELAY_RESET = 16'd10;
  localparam logic [7:0] DROP_MARK_BYTE = 8'h3F;

  typedef struct packed {
    logic       nonempty;
    logic [7:0] head_byte;
  } fifo_stat_t;

  typedef struct packed {
    logic scl_release;
    logic sda_release;
    logic busy;
    logic nak;
  } bus_drive_t;

endpackage

// ----- sv/i2cdbt_fifo.sv -----
// Message byte queue with whole-message drop and a '?' marker for dropped messages.
// Holds the byte memory, pointers and fill count; uses i2cdbt_pkg.
module i2cdbt_fifo #(
  parameter int unsigned Depth = 128
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   push_valid_i,
  input  logic [7:0]             push_byte_i,
  input  logic                   message_first_i,
  input  logic [7:0]             message_length_i,
  input  logic                   get_i,
  output i2cdbt_pkg::fifo_stat_t stat_o,
  output logic                   push_accepted_o,
  output logic [7:0]             fifo_level_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned SumW = ((CntW > 8) ? CntW : 8) + 1;

  logic [7:0]      mem [Depth];
  logic [7:0]      rd_q;
  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d, count_push;
  logic            drop_q, drop_d;
  logic            put;
  logic [7:0]      put_val;
  logic            room, fits;
  logic [SumW-1:0] fit_sum;

  always_comb begin
    room    = count_q < CntW'(Depth);
    fit_sum = SumW'(count_q) + SumW'(message_length_i);
    fits    = fit_sum <= SumW'(Depth);
    put     = 1'b0;
    put_val = push_byte_i;
    drop_d  = drop_q;
    push_accepted_o = 1'b0;
    if (push_valid_i) begin
      if (message_first_i) begin
        if (!fits) begin
          drop_d  = 1'b1;
          put     = room;
          put_val = i2cdbt_pkg::DROP_MARK_BYTE;
        end else begin
          drop_d = 1'b0;
          put    = room;
          push_accepted_o = room;
        end
      end else if (!drop_q && room) begin
        put = 1'b1;
        push_accepted_o = 1'b1;
      end
    end
    count_push = count_q + CntW'(put);
    count_d    = count_push - CntW'(get_i);
    tail_d     = tail_q;
    if (put) begin
      tail_d = (tail_q == PtrW'(Depth - 1)) ? '0 : tail_q + 1'b1;
    end
    head_d = head_q;
    if (get_i) begin
      head_d = (head_q == PtrW'(Depth - 1)) ? '0 : head_q + 1'b1;
    end
    stat_o.nonempty  = count_push != '0;
    stat_o.head_byte = (count_q == '0) ? put_val : rd_q;
    fifo_level_o     = 8'(count_d);
  end

  always_ff @(posedge clk_i) begin
    if (en_i && put) begin
      mem[tail_q] <= put_val;
    end
    if (en_i && put && (tail_q == head_q)) begin
      rd_q <= put_val;
    end else begin
      rd_q <= mem[head_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      drop_q  <= 1'b0;
    end else if (en_i) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      drop_q  <= drop_d;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("fill count above depth");
  a_get_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && get_i) |-> (count_push != '0))
    else $error("read from an empty queue");
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == tail_q))
    else $error("empty queue with unequal pointers");
  a_accept_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_accepted_o |-> put)
    else $error("byte reported queued without a write");
`endif

endmodule

// ----- sv/i2cdbt_seq.sv -----
// Bit-level I2C write sequencer: start, address, data bytes, ACK check, retry and stop.
// Updates its phase state once per item (en_i); uses i2cdbt_pkg.
module i2cdbt_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   scl_line_i,
  input  logic                   sda_line_i,
  input  logic [15:0]            bit_delay_i,
  input  logic [6:0]             target_address_i,
  input  i2cdbt_pkg::fifo_stat_t stat_i,
  output logic                   get_o,
  output i2cdbt_pkg::bus_drive_t drive_o
);

  i2cdbt_pkg::phase_e phase_q, phase_d;
  logic [2:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [19:0] wait_q, wait_d;
  logic        resend_q, resend_d;
  logic        addr_q, addr_d;
  logic        ack_q, ack_d;
  logic        nak;
  logic [7:0]  tx_val;
  logic        tx_bit;

  function automatic logic [19:0] phase_delay(i2cdbt_pkg::phase_e p, logic [15:0] bd);
    logic [19:0] full;
    logic [19:0] half;
    logic [19:0] d;
    full = {4'b0, bd};
    half = {5'b0, bd[15:1]};
    unique case (p)
      i2cdbt_pkg::PH_ST_HOLD, i2cdbt_pkg::PH_BIT_HIGH, i2cdbt_pkg::PH_SP_HIGH: d = full;
      i2cdbt_pkg::PH_ST_SETUP, i2cdbt_pkg::PH_ST_LOW, i2cdbt_pkg::PH_BIT_SETUP,
      i2cdbt_pkg::PH_BIT_LOW, i2cdbt_pkg::PH_ACK_SETUP, i2cdbt_pkg::PH_ACK_SAMPLE,
      i2cdbt_pkg::PH_ACK_HOLD, i2cdbt_pkg::PH_SP_LOW, i2cdbt_pkg::PH_SP_TAIL: d = half;
      i2cdbt_pkg::PH_ACK_TAIL: d = (half << 1) + (full << 1);
      i2cdbt_pkg::PH_RETRY: d = (full << 3) + (full << 1);
      default: d = '0;
    endcase
    return (d == '0) ? 20'd1 : d;
  endfunction

  always_comb begin
    phase_d  = phase_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    wait_d   = wait_q;
    resend_d = resend_q;
    addr_d   = addr_q;
    ack_d    = ack_q;
    get_o    = 1'b0;
    nak      = 1'b0;
    unique case (phase_q)
      i2cdbt_pkg::PH_IDLE: begin
        if (resend_q || stat_i.nonempty) phase_d = i2cdbt_pkg::PH_ST_SDA_SYNC;
      end
      i2cdbt_pkg::PH_ST_SDA_SYNC: if (sda_line_i) phase_d = i2cdbt_pkg::PH_ST_SCL_SYNC;
      i2cdbt_pkg::PH_ST_SCL_SYNC: if (scl_line_i) phase_d = i2cdbt_pkg::PH_ST_SETUP;
      i2cdbt_pkg::PH_BIT_SYNC:    if (scl_line_i) phase_d = i2cdbt_pkg::PH_BIT_HIGH;
      i2cdbt_pkg::PH_ACK_SYNC:    if (scl_line_i) phase_d = i2cdbt_pkg::PH_ACK_SAMPLE;
      i2cdbt_pkg::PH_CLN_SCL:     if (scl_line_i) phase_d = i2cdbt_pkg::PH_CLN_SDA;
      i2cdbt_pkg::PH_CLN_SDA:     if (sda_line_i) phase_d = i2cdbt_pkg::PH_RETRY;
      i2cdbt_pkg::PH_SP_SYNC:     if (scl_line_i) phase_d = i2cdbt_pkg::PH_SP_HIGH;
      i2cdbt_pkg::PH_SP_SDA_SYNC: if (sda_line_i) phase_d = i2cdbt_pkg::PH_SP_TAIL;
      default: begin
        if (wait_q > 20'd1) begin
          wait_d = wait_q - 20'd1;
        end else begin
          unique case (phase_q)
            i2cdbt_pkg::PH_ST_SETUP: phase_d = i2cdbt_pkg::PH_ST_HOLD;
            i2cdbt_pkg::PH_ST_HOLD:  phase_d = i2cdbt_pkg::PH_ST_LOW;
            i2cdbt_pkg::PH_ST_LOW: begin
              addr_d  = 1'b1;
              bit_d   = '0;
              phase_d = i2cdbt_pkg::PH_BIT_SETUP;
            end
            i2cdbt_pkg::PH_BIT_SETUP: phase_d = i2cdbt_pkg::PH_BIT_SYNC;
            i2cdbt_pkg::PH_BIT_HIGH:  phase_d = i2cdbt_pkg::PH_BIT_LOW;
            i2cdbt_pkg::PH_BIT_LOW: begin
              if (bit_q == 3'd7) begin
                bit_d   = '0;
                phase_d = i2cdbt_pkg::PH_ACK_SETUP;
              end else begin
                bit_d   = bit_q + 3'd1;
                phase_d = i2cdbt_pkg::PH_BIT_SETUP;
              end
            end
            i2cdbt_pkg::PH_ACK_SETUP: phase_d = i2cdbt_pkg::PH_ACK_SYNC;
            i2cdbt_pkg::PH_ACK_SAMPLE: begin
              ack_d   = !sda_line_i;
              nak     = sda_line_i;
              phase_d = i2cdbt_pkg::PH_ACK_HOLD;
            end
            i2cdbt_pkg::PH_ACK_HOLD: phase_d = i2cdbt_pkg::PH_ACK_TAIL;
            i2cdbt_pkg::PH_ACK_TAIL: begin
              if (ack_q) begin
                if (!addr_q) resend_d = 1'b0;
                if (resend_d || stat_i.nonempty) begin
                  if (!resend_d) begin
                    shift_d = stat_i.head_byte;
                    get_o   = 1'b1;
                  end
                  addr_d  = 1'b0;
                  bit_d   = '0;
                  phase_d = i2cdbt_pkg::PH_BIT_SETUP;
                end else begin
                  phase_d = i2cdbt_pkg::PH_SP_LOW;
                end
              end else begin
                if (!addr_q) resend_d = 1'b1;
                phase_d = i2cdbt_pkg::PH_CLN_SCL;
              end
            end
            i2cdbt_pkg::PH_RETRY: begin
              phase_d = (resend_q || stat_i.nonempty) ? i2cdbt_pkg::PH_ST_SDA_SYNC
                                                      : i2cdbt_pkg::PH_IDLE;
            end
            i2cdbt_pkg::PH_SP_LOW:  phase_d = i2cdbt_pkg::PH_SP_SYNC;
            i2cdbt_pkg::PH_SP_HIGH: phase_d = i2cdbt_pkg::PH_SP_SDA_SYNC;
            default: phase_d = i2cdbt_pkg::PH_IDLE;
          endcase
        end
      end
    endcase
    if (phase_d != phase_q) begin
      wait_d = phase_delay(phase_d, bit_delay_i);
    end else if (wait_q <= 20'd1 && phase_q != i2cdbt_pkg::PH_IDLE) begin
      wait_d = phase_delay(phase_d, bit_delay_i);
    end

    tx_val = addr_d ? {target_address_i, 1'b0} : shift_d;
    tx_bit = tx_val[3'd7 - bit_d];
    drive_o.busy = phase_d != i2cdbt_pkg::PH_IDLE;
    drive_o.nak  = nak;
    unique case (phase_d)
      i2cdbt_pkg::PH_ST_HOLD: begin
        drive_o.scl_release = 1'b1;
        drive_o.sda_release = 1'b0;
      end
      i2cdbt_pkg::PH_ST_LOW, i2cdbt_pkg::PH_SP_LOW: begin
        drive_o.scl_release = 1'b0;
        drive_o.sda_release = 1'b0;
      end
      i2cdbt_pkg::PH_BIT_SETUP, i2cdbt_pkg::PH_BIT_LOW: begin
        drive_o.scl_release = 1'b0;
        drive_o.sda_release = tx_bit;
      end
      i2cdbt_pkg::PH_BIT_SYNC, i2cdbt_pkg::PH_BIT_HIGH: begin
        drive_o.scl_release = 1'b1;
        drive_o.sda_release = tx_bit;
      end
      i2cdbt_pkg::PH_ACK_SETUP, i2cdbt_pkg::PH_ACK_TAIL: begin
        drive_o.scl_release = 1'b0;
        drive_o.sda_release = 1'b1;
      end
      i2cdbt_pkg::PH_SP_SYNC, i2cdbt_pkg::PH_SP_HIGH: begin
        drive_o.scl_release = 1'b1;
        drive_o.sda_release = 1'b0;
      end
      default: begin
        drive_o.scl_release = 1'b1;
        drive_o.sda_release = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= i2cdbt_pkg::PH_IDLE;
      bit_q    <= '0;
      shift_q  <= '0;
      wait_q   <= '0;
      resend_q <= 1'b0;
      addr_q   <= 1'b0;
      ack_q    <= 1'b0;
    end else if (en_i) begin
      phase_q  <= phase_d;
      bit_q    <= bit_d;
      shift_q  <= shift_d;
      wait_q   <= wait_d;
      resend_q <= resend_d;
      addr_q   <= addr_d;
      ack_q    <= ack_d;
    end
  end

`ifndef SYNTHESIS
  a_nak_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && nak) |-> (phase_q == i2cdbt_pkg::PH_ACK_SAMPLE))
    else $error("NAK reported outside the ACK sample");
  a_get_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && get_o) |-> (phase_q == i2cdbt_pkg::PH_ACK_TAIL && !resend_d))
    else $error("queue read outside a byte boundary");
  a_wait_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != i2cdbt_pkg::PH_IDLE) |-> (wait_q != '0))
    else $error("active phase with no delay loaded");
`endif

endmodule

// ----- sv/i2cdbt_top.sv -----
// I2C debug byte transmitter top level: an item is captured in the input register on accept;
// its result is loaded into the result register when the output is free. One item per cycle
// unless m_axis_tready stalls, with one registered update of the queue and sequencer per item.
// Reset (asynchronous, active low) empties the queue, sets the sequencer idle, sets
// bit_delay to 10 and target_address to 0; queue memory contents are not cleared.
// Depends on i2cdbt_pkg, i2cdbt_fifo and i2cdbt_seq.
module i2c_debug_byte_transmitter_unit #(
  parameter int unsigned FIFO_DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // push_byte[7:0], message_length[15:8], scl_line[16], sda_line[17], zeros above.
  input  logic [23:0] s_axis_tdata,
  // push_valid[0], message_first[1].
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // scl_release[0], sda_release[1], busy_res[2], push_accepted[3], fifo_level[11:4],
  // nak_seen[12], zeros above.
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [i2cdbt_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic        in_valid_q;
  logic [23:0] in_data_q;
  logic [1:0]  in_user_q;
  logic        out_valid_q;
  logic [15:0] out_data_q, out_data_d;
  logic        advance;
  logic [15:0] bit_delay_q;
  logic [6:0]  target_q;
  logic        get;
  logic        accepted;
  logic [7:0]  level;
  i2cdbt_pkg::fifo_stat_t stat;
  i2cdbt_pkg::bus_drive_t drive;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_delay_q <= i2cdbt_pkg::BIT_DELAY_RESET;
      target_q    <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == i2cdbt_pkg::CFG_BIT_DELAY) begin
        bit_delay_q <= cfg_data_i;
      end else if (cfg_index_i == i2cdbt_pkg::CFG_TARGET_ADDRESS) begin
        target_q <= cfg_data_i[6:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_user_q <= s_axis_tuser;
    end
    if (advance) out_data_q <= out_data_d;
  end

  i2cdbt_fifo #(
    .Depth(FIFO_DEPTH)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .en_i             (advance),
    .push_valid_i     (in_user_q[0]),
    .push_byte_i      (in_data_q[7:0]),
    .message_first_i  (in_user_q[1]),
    .message_length_i (in_data_q[15:8]),
    .get_i            (get),
    .stat_o           (stat),
    .push_accepted_o  (accepted),
    .fifo_level_o     (level)
  );

  i2cdbt_seq u_seq (
    .clk_i,
    .rst_ni,
    .en_i             (advance),
    .scl_line_i       (in_data_q[16]),
    .sda_line_i       (in_data_q[17]),
    .bit_delay_i      (bit_delay_q),
    .target_address_i (target_q),
    .stat_i           (stat),
    .get_o            (get),
    .drive_o          (drive)
  );

  assign out_data_d = {3'b000, drive.nak, level, accepted, drive.busy,
                       drive.sda_release, drive.scl_release};

`ifndef SYNTHESIS
  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("processed item produced no result");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !advance)
    else $error("result overwritten while stalled");
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("pending item lost");
`endif

endmodule
